@@ rtl/core/nec_ir_pkg.sv @@
// Shared types and constants for the NEC infrared pulse decoder.
`timescale 1ns / 1ps

package nec_ir_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int FRAME_BITS  = 32;
    localparam int REPEAT_SKIP = 2;
    localparam int TICK_W      = 16;
    localparam int CNT_W       = 4;
    localparam int KEY_W       = 8;
    localparam int CFG_IDX_W   = 3;

    localparam logic [KEY_W-1:0] BAD_KEY = 8'hff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_MIN    = 3'd0,
        CFG_HEADER_MAX    = 3'd1,
        CFG_REPEAT_MIN    = 3'd2,
        CFG_REPEAT_MAX    = 3'd3,
        CFG_BIT_MIN       = 3'd4,
        CFG_BIT_MAX       = 3'd5,
        CFG_ONE_THRESHOLD = 3'd6,
        CFG_CHECK_ADDRESS = 3'd7
    } cfg_index_t;

    typedef enum logic {
        ACT_EDGE = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef struct packed {
        logic [TICK_W-1:0] header_min;
        logic [TICK_W-1:0] header_max;
        logic [TICK_W-1:0] repeat_min;
        logic [TICK_W-1:0] repeat_max;
        logic [TICK_W-1:0] bit_min;
        logic [TICK_W-1:0] bit_max;
        logic [TICK_W-1:0] one_threshold;
        logic              check_address;
    } nec_ir_cfg_t;

    // Classified item handed from front to back
    typedef struct packed {
        action_t action;
        logic    header_hit;
        logic    repeat_hit;
        logic    bit_hit;
        logic    bit_one;
    } nec_ir_item_t;

endpackage

@@ rtl/core/nec_ir_pulse_decoder_unit.sv @@
// Top level of the NEC infrared pulse decoder with configuration registers.
// A result reaches m_ after its input transaction passes the front register,
// a queue slot and the result register.
// Throughput: one transaction per cycle unless m_tready stalls the result register.
// Reset: synchronous active-low aresetn restores register defaults, empties the
// ring and queue, and returns the frame machine to its first-edge phase.
`timescale 1ns / 1ps

module nec_ir_pulse_decoder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] interval_ticks
    input  logic        s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] key_code, [8] repeat_flag, [12:9] entries_waiting
    output logic        m_tuser,   // [0] read_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    nec_ir_pkg::nec_ir_cfg_t  cfg_reg;
    nec_ir_pkg::nec_ir_item_t front_item;
    nec_ir_pkg::nec_ir_item_t queue_item;
    logic                     front_valid, front_ready;
    logic                     queue_valid, queue_ready;
    logic [nec_ir_pkg::KEY_W-1:0] key_code;
    logic                     repeat_flag;
    logic [nec_ir_pkg::CNT_W-1:0] entries_waiting;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_min    <= 16'd13000;
            cfg_reg.header_max    <= 16'd14000;
            cfg_reg.repeat_min    <= 16'd10500;
            cfg_reg.repeat_max    <= 16'd12000;
            cfg_reg.bit_min       <= 16'd900;
            cfg_reg.bit_max       <= 16'd2500;
            cfg_reg.one_threshold <= 16'd1700;
            cfg_reg.check_address <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (nec_ir_pkg::cfg_index_t'(cfg_index))
                nec_ir_pkg::CFG_HEADER_MIN:    cfg_reg.header_min    <= cfg_data;
                nec_ir_pkg::CFG_HEADER_MAX:    cfg_reg.header_max    <= cfg_data;
                nec_ir_pkg::CFG_REPEAT_MIN:    cfg_reg.repeat_min    <= cfg_data;
                nec_ir_pkg::CFG_REPEAT_MAX:    cfg_reg.repeat_max    <= cfg_data;
                nec_ir_pkg::CFG_BIT_MIN:       cfg_reg.bit_min       <= cfg_data;
                nec_ir_pkg::CFG_BIT_MAX:       cfg_reg.bit_max       <= cfg_data;
                nec_ir_pkg::CFG_ONE_THRESHOLD: cfg_reg.one_threshold <= cfg_data;
                nec_ir_pkg::CFG_CHECK_ADDRESS: cfg_reg.check_address <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    nec_ir_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_ticks  (s_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    nec_ir_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    nec_ir_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .check_address       (cfg_reg.check_address),
        .in_valid            (queue_valid),
        .in_ready            (queue_ready),
        .in_item             (queue_item),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .out_read_valid      (m_tuser),
        .out_key_code        (key_code),
        .out_repeat_flag     (repeat_flag),
        .out_entries_waiting (entries_waiting)
    );

    assign m_tdata = {3'b000, entries_waiting, repeat_flag, key_code};

endmodule

@@ rtl/core/nec_ir_front.sv @@
// Front stage: accepts input transactions and classifies the interval.
`timescale 1ns / 1ps

module nec_ir_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  nec_ir_pkg::nec_ir_cfg_t             cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_action,
    input  logic [nec_ir_pkg::TICK_W-1:0]       in_ticks,
    output logic                                out_valid,
    input  logic                                out_ready,
    output nec_ir_pkg::nec_ir_item_t            out_item
);

    logic                     valid_reg;
    nec_ir_pkg::nec_ir_item_t item_reg;
    nec_ir_pkg::nec_ir_item_t item_next;

    always_comb begin
        item_next.action     = nec_ir_pkg::action_t'(in_action);
        item_next.header_hit = (cfg.header_min < in_ticks) && (in_ticks < cfg.header_max);
        item_next.repeat_hit = (cfg.repeat_min < in_ticks) && (in_ticks < cfg.repeat_max);
        item_next.bit_hit    = (cfg.bit_min < in_ticks) && (in_ticks < cfg.bit_max);
        item_next.bit_one    = in_ticks > cfg.one_threshold;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/nec_ir_queue.sv @@
// Two-entry queue between the front and back stages.
`timescale 1ns / 1ps

module nec_ir_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  nec_ir_pkg::nec_ir_item_t in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output nec_ir_pkg::nec_ir_item_t out_item
);

    nec_ir_pkg::nec_ir_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/core/nec_ir_back.sv @@
// Back stage: frame state machine, key ring and result register.
`timescale 1ns / 1ps

module nec_ir_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                check_address,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  nec_ir_pkg::nec_ir_item_t            in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_read_valid,
    output logic [nec_ir_pkg::KEY_W-1:0]        out_key_code,
    output logic                                out_repeat_flag,
    output logic [nec_ir_pkg::CNT_W-1:0]        out_entries_waiting
);

    localparam int AW    = nec_ir_pkg::RING_AW;
    localparam int KW    = nec_ir_pkg::KEY_W;
    localparam int FB    = nec_ir_pkg::FRAME_BITS;
    localparam int BCW   = 6;
    localparam int RCW   = 4;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [BCW-1:0]  bits_reg, bits_next;
    logic [RCW-1:0]  repeats_reg, repeats_next;
    logic [FB-1:0]   shift_reg, shift_next;
    logic [KW-1:0]   last_key_reg, last_key_next;
    logic            last_rep_reg, last_rep_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [AW-1:0]   tail_reg, tail_next;
    logic [KW:0]     ring_mem [nec_ir_pkg::RING_DEPTH];

    logic            out_valid_reg;
    logic            read_valid_reg;
    logic [KW-1:0]   key_reg;
    logic            rep_reg;
    logic [nec_ir_pkg::CNT_W-1:0] waiting_reg;

    logic            fire;
    logic            push;
    logic [KW:0]     push_data;
    logic [AW-1:0]   head_inc;
    logic [AW-1:0]   tail_inc;
    logic            res_valid;
    logic [AW:0]     count_next;
    logic            frame_ok;

    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign head_inc = (head_reg == AW'(nec_ir_pkg::RING_DEPTH - 1)) ? '0 : head_reg + AW'(1);
    assign tail_inc = (tail_reg == AW'(nec_ir_pkg::RING_DEPTH - 1)) ? '0 : tail_reg + AW'(1);

    always_comb begin
        phase_next    = phase_reg;
        bits_next     = bits_reg;
        repeats_next  = repeats_reg;
        shift_next    = shift_reg;
        last_key_next = last_key_reg;
        last_rep_next = last_rep_reg;
        tail_next     = tail_reg;
        push          = 1'b0;
        push_data     = {1'b0, last_key_reg};
        res_valid     = 1'b0;
        frame_ok      = 1'b0;

        if (in_item.action == nec_ir_pkg::ACT_READ) begin
            if (head_reg != tail_reg) begin
                tail_next = tail_inc;
                res_valid = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                PH_START: begin
                    phase_next = PH_HEADER;
                end
                PH_HEADER: begin
                    if (in_item.header_hit) begin
                        phase_next   = PH_DATA;
                        bits_next    = '0;
                        repeats_next = '0;
                    end else if (in_item.repeat_hit) begin
                        if (repeats_reg == RCW'(nec_ir_pkg::REPEAT_SKIP)) begin
                            repeats_next  = '0;
                            last_rep_next = 1'b1;
                            phase_next    = PH_START;
                            push          = 1'b1;
                            push_data     = {1'b1, last_key_reg};
                        end else begin
                            repeats_next = repeats_reg + RCW'(1);
                        end
                    end
                end
                PH_DATA: begin
                    if (in_item.bit_hit) begin
                        bits_next  = bits_reg + BCW'(1);
                        shift_next = {in_item.bit_one, shift_reg[FB-1:1]};
                        if (bits_next >= BCW'(FB)) begin
                            frame_ok = (shift_next[23:16] == ~shift_next[31:24]) &&
                                       (!check_address ||
                                        (shift_next[7:0] == ~shift_next[15:8]));
                            last_rep_next = 1'b0;
                            phase_next    = PH_HEADER;
                            if (frame_ok) begin
                                last_key_next = shift_next[23:16];
                                push          = 1'b1;
                                push_data     = {1'b0, shift_next[23:16]};
                            end else begin
                                last_key_next = nec_ir_pkg::BAD_KEY;
                            end
                        end
                    end
                end
                default: begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        // ring drops the push when full
        if (push && head_inc != tail_reg) begin
            head_next = head_inc;
        end else begin
            head_next = head_reg;
            push      = 1'b0;
        end

        if (head_next >= tail_next) begin
            count_next = {1'b0, head_next} - {1'b0, tail_next};
        end else begin
            count_next = {1'b0, head_next} + (AW+1)'(nec_ir_pkg::RING_DEPTH)
                         - {1'b0, tail_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_START;
            bits_reg       <= '0;
            repeats_reg    <= '0;
            shift_reg      <= '0;
            last_key_reg   <= '0;
            last_rep_reg   <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg    <= phase_next;
                bits_reg     <= bits_next;
                repeats_reg  <= repeats_next;
                shift_reg    <= shift_next;
                last_key_reg <= last_key_next;
                last_rep_reg <= last_rep_next;
                head_reg     <= head_next;
                tail_reg     <= tail_next;
            end
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            read_valid_reg <= res_valid;
            key_reg        <= res_valid ? ring_mem[tail_reg][KW-1:0] : '0;
            rep_reg        <= res_valid ? ring_mem[tail_reg][KW] : 1'b0;
            waiting_reg    <= nec_ir_pkg::CNT_W'(count_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && push) begin
            ring_mem[head_reg] <= push_data;
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_read_valid      = read_valid_reg;
    assign out_key_code        = key_reg;
    assign out_repeat_flag     = rep_reg;
    assign out_entries_waiting = waiting_reg;

endmodule

@@ tb/sv/tb_nec_ir_pulse_decoder_unit.sv @@
// Self-checking testbench for the NEC infrared pulse decoder unit.
`timescale 1ns / 1ps

module tb_nec_ir_pulse_decoder_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 27;
    localparam int KEY_W          = nec_ir_pkg::KEY_W;
    localparam int CNT_W          = nec_ir_pkg::CNT_W;
    localparam int RING_AW        = nec_ir_pkg::RING_AW;

    localparam nec_ir_pkg::nec_ir_cfg_t DEFAULT_WINDOWS = '{
        header_min: 16'd13000, header_max: 16'd14000,
        repeat_min: 16'd10500, repeat_max: 16'd12000,
        bit_min: 16'd900, bit_max: 16'd2500,
        one_threshold: 16'd1700, check_address: 1'b1
    };

    typedef enum logic [1:0] {
        PH_FIRST_EDGE = 2'd0,
        PH_HEADER     = 2'd1,
        PH_DATA       = 2'd2
    } frame_phase_t;

    typedef struct packed {
        logic             read_valid;
        logic [KEY_W-1:0] key_code;
        logic             repeat_flag;
        logic [CNT_W-1:0] entries_waiting;
    } ir_report_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    nec_ir_pulse_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // decoder shadow state
    nec_ir_pkg::nec_ir_cfg_t regs        = DEFAULT_WINDOWS;
    frame_phase_t         ir_phase       = PH_FIRST_EDGE;
    logic [5:0]           bits_received  = '0;
    logic [CNT_W-1:0]     repeats_seen   = '0;
    logic [31:0]          shift_word     = '0;
    logic [KEY_W-1:0]     last_key       = '0;
    logic [KEY_W:0]       ring_mem [nec_ir_pkg::RING_DEPTH];
    logic [RING_AW-1:0]   ring_wr        = '0;
    logic [RING_AW-1:0]   ring_rd        = '0;

    ir_report_t pending_reports [$];
    ir_report_t due;
    bit         no_idle        = 1'b0;
    int         errors         = 0;
    int         items_sent     = 0;
    int         results_seen   = 0;
    int         settings_used  = 0;
    int         keys_pushed    = 0;
    int         repeats_pushed = 0;
    int         pushes_dropped = 0;
    int         frames_rejected = 0;
    int         quiet_cycles   = 0;

    function automatic void ring_push(input logic [KEY_W:0] entry);
        if (RING_AW'(ring_wr + RING_AW'(1)) != ring_rd) begin
            ring_mem[ring_wr] = entry;
            ring_wr = RING_AW'(ring_wr + RING_AW'(1));
            if (entry[KEY_W]) repeats_pushed++;
            else keys_pushed++;
        end else begin
            pushes_dropped++;
        end
    endfunction

    function automatic void decode_edge(input logic [15:0] t);
        unique case (ir_phase)
            PH_FIRST_EDGE: ir_phase = PH_HEADER;
            PH_HEADER: begin
                if (t > regs.header_min && t < regs.header_max) begin
                    ir_phase = PH_DATA;
                    bits_received = '0;
                    repeats_seen = '0;
                end else if (t > regs.repeat_min && t < regs.repeat_max) begin
                    if (repeats_seen == CNT_W'(nec_ir_pkg::REPEAT_SKIP)) begin
                        repeats_seen = '0;
                        ir_phase = PH_FIRST_EDGE;
                        ring_push({1'b1, last_key});
                    end else begin
                        repeats_seen = repeats_seen + CNT_W'(1);
                    end
                end
            end
            PH_DATA: begin
                if (t > regs.bit_min && t < regs.bit_max) begin
                    bits_received = bits_received + 6'd1;
                    shift_word = {t > regs.one_threshold, shift_word[31:1]};
                    if (bits_received >= 6'(nec_ir_pkg::FRAME_BITS)) begin
                        if (shift_word[23:16] == ~shift_word[31:24] &&
                            (!regs.check_address || shift_word[7:0] == ~shift_word[15:8])) begin
                            last_key = shift_word[23:16];
                            ring_push({1'b0, last_key});
                        end else begin
                            last_key = nec_ir_pkg::BAD_KEY;
                            frames_rejected++;
                        end
                        ir_phase = PH_HEADER;
                    end
                end
            end
            default: ir_phase = PH_HEADER;
        endcase
    endfunction

    function automatic ir_report_t decode_item(input nec_ir_pkg::action_t act,
                                               input logic [15:0] t);
        ir_report_t r;
        r = '0;
        if (act == nec_ir_pkg::ACT_EDGE) begin
            decode_edge(t);
        end else if (ring_wr != ring_rd) begin
            r.read_valid  = 1'b1;
            r.key_code    = ring_mem[ring_rd][KEY_W-1:0];
            r.repeat_flag = ring_mem[ring_rd][KEY_W];
            ring_rd = RING_AW'(ring_rd + RING_AW'(1));
        end
        r.entries_waiting = CNT_W'(ring_wr - ring_rd);
        return r;
    endfunction

    function automatic logic [15:0] pick_between(input int lo, input int hi);
        if (hi - lo >= 2) return 16'($urandom_range(hi - 1, lo + 1));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] one_ticks();
        int lo;
        lo = (regs.one_threshold > regs.bit_min) ? int'(regs.one_threshold) : int'(regs.bit_min);
        return pick_between(lo, int'(regs.bit_max));
    endfunction

    function automatic logic [15:0] zero_ticks();
        int hi;
        hi = int'(regs.one_threshold) + 1;
        if (hi > int'(regs.bit_max)) hi = int'(regs.bit_max);
        return pick_between(int'(regs.bit_min), hi);
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual tuser=%b tdata=%h",
                         $time, m_tuser, m_tdata);
                errors++;
            end else begin
                due = pending_reports.pop_front();
                check_field("read_valid", int'(due.read_valid), int'(m_tuser));
                check_field("key_code", int'(due.key_code), int'(m_tdata[7:0]));
                check_field("repeat_flag", int'(due.repeat_flag), int'(m_tdata[8]));
                check_field("entries_waiting", int'(due.entries_waiting),
                            int'(m_tdata[12:9]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d transactions still pending", $time,
                         pending_reports.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_item(input nec_ir_pkg::action_t act, input logic [15:0] ticks);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ticks;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_reports.push_back(decode_item(act, ticks));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic write_reg(input nec_ir_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        unique case (idx)
            nec_ir_pkg::CFG_HEADER_MIN:    regs.header_min    = val;
            nec_ir_pkg::CFG_HEADER_MAX:    regs.header_max    = val;
            nec_ir_pkg::CFG_REPEAT_MIN:    regs.repeat_min    = val;
            nec_ir_pkg::CFG_REPEAT_MAX:    regs.repeat_max    = val;
            nec_ir_pkg::CFG_BIT_MIN:       regs.bit_min       = val;
            nec_ir_pkg::CFG_BIT_MAX:       regs.bit_max       = val;
            nec_ir_pkg::CFG_ONE_THRESHOLD: regs.one_threshold = val;
            nec_ir_pkg::CFG_CHECK_ADDRESS: regs.check_address = val[0];
            default: ;
        endcase
    endtask

    task automatic load_regs(input nec_ir_pkg::nec_ir_cfg_t c);
        write_reg(nec_ir_pkg::CFG_HEADER_MIN, c.header_min);
        write_reg(nec_ir_pkg::CFG_HEADER_MAX, c.header_max);
        write_reg(nec_ir_pkg::CFG_REPEAT_MIN, c.repeat_min);
        write_reg(nec_ir_pkg::CFG_REPEAT_MAX, c.repeat_max);
        write_reg(nec_ir_pkg::CFG_BIT_MIN, c.bit_min);
        write_reg(nec_ir_pkg::CFG_BIT_MAX, c.bit_max);
        write_reg(nec_ir_pkg::CFG_ONE_THRESHOLD, c.one_threshold);
        write_reg(nec_ir_pkg::CFG_CHECK_ADDRESS, {15'd0, c.check_address});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_frame();
        logic [7:0]  addr, cmd, naddr, ncmd;
        logic [31:0] word;
        addr  = 8'($urandom);
        cmd   = 8'($urandom);
        naddr = ($urandom_range(99) < 80) ? ~addr : 8'($urandom);
        ncmd  = ($urandom_range(99) < 85) ? ~cmd : 8'($urandom);
        word  = {ncmd, cmd, naddr, addr};
        if (ir_phase == PH_FIRST_EDGE) send_item(nec_ir_pkg::ACT_EDGE, 16'($urandom));
        if (ir_phase != PH_DATA)
            send_item(nec_ir_pkg::ACT_EDGE,
                      pick_between(int'(regs.header_min), int'(regs.header_max)));
        for (int i = int'(bits_received); i < nec_ir_pkg::FRAME_BITS; i++) begin
            if ($urandom_range(99) < 4) send_item(nec_ir_pkg::ACT_EDGE, 16'($urandom));
            send_item(nec_ir_pkg::ACT_EDGE, word[i] ? one_ticks() : zero_ticks());
        end
    endtask

    task automatic send_repeats();
        int n;
        n = $urandom_range(4, 1);
        if (ir_phase == PH_FIRST_EDGE) send_item(nec_ir_pkg::ACT_EDGE, 16'($urandom));
        repeat (n)
            send_item(nec_ir_pkg::ACT_EDGE,
                      pick_between(int'(regs.repeat_min), int'(regs.repeat_max)));
    endtask

    task automatic random_traffic(input int n_items, input int frame_pct,
                                  input int repeat_pct, input int read_pct);
        int start;
        int r;
        start = items_sent;
        while (items_sent - start < n_items) begin
            r = $urandom_range(99);
            if (r < frame_pct)
                send_frame();
            else if (r < frame_pct + repeat_pct)
                send_repeats();
            else if (r < frame_pct + repeat_pct + read_pct)
                repeat ($urandom_range(3, 1)) send_item(nec_ir_pkg::ACT_READ, 16'($urandom));
            else
                repeat ($urandom_range(3, 1)) send_item(nec_ir_pkg::ACT_EDGE, 16'($urandom));
        end
        wait_idle();
    endtask

    // reset windows; window bounds are exclusive, repeat after two skipped
    task automatic test_header_windows();
        send_item(nec_ir_pkg::ACT_READ, 16'hffff);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd0);
        send_item(nec_ir_pkg::ACT_EDGE, 16'hffff);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd0);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd13000);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd14000);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd10500);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd12000);
        repeat (3) send_item(nec_ir_pkg::ACT_EDGE, 16'd11000);
        send_item(nec_ir_pkg::ACT_READ, 16'd0);
        send_item(nec_ir_pkg::ACT_READ, 16'd0);
        wait_idle();
    endtask

    task automatic test_data_windows();
        send_item(nec_ir_pkg::ACT_EDGE, 16'hffff);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd13500);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd900);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd2500);
        send_item(nec_ir_pkg::ACT_EDGE, 16'd0);
        send_item(nec_ir_pkg::ACT_EDGE, 16'hffff);
        wait_idle();
    endtask

    task automatic test_mixed_traffic();
        random_traffic(200, 40, 25, 20);
    endtask

    task automatic test_ring_overflow();
        load_regs('{header_min: 16'd9000, header_max: 16'd9600,
                    repeat_min: 16'd7000, repeat_max: 16'd8000,
                    bit_min: 16'd300, bit_max: 16'd1200,
                    one_threshold: 16'd700, check_address: 1'b0});
        no_idle = 1'b1;
        random_traffic(160, 15, 75, 2);
        no_idle = 1'b0;
    endtask

    task automatic test_open_windows();
        load_regs('{header_min: 16'd0, header_max: 16'hffff,
                    repeat_min: 16'd0, repeat_max: 16'hffff,
                    bit_min: 16'd0, bit_max: 16'hffff,
                    one_threshold: 16'd0, check_address: 1'b1});
        random_traffic(70, 40, 20, 20);
    endtask

    task automatic test_closed_windows();
        load_regs('{header_min: 16'hffff, header_max: 16'd0,
                    repeat_min: 16'hffff, repeat_max: 16'd0,
                    bit_min: 16'hffff, bit_max: 16'd0,
                    one_threshold: 16'hffff, check_address: 1'b0});
        random_traffic(40, 30, 30, 20);
    endtask

    task automatic test_random_windows();
        nec_ir_pkg::nec_ir_cfg_t c;
        c.header_min    = 16'($urandom_range(60000, 30000));
        c.header_max    = c.header_min + 16'($urandom_range(3000, 2));
        c.repeat_min    = 16'($urandom_range(28000, 15000));
        c.repeat_max    = c.repeat_min + 16'($urandom_range(2000, 2));
        c.bit_min       = 16'($urandom_range(4000, 0));
        c.bit_max       = c.bit_min + 16'($urandom_range(6000, 4));
        c.one_threshold = c.bit_min + 16'($urandom_range(int'(c.bit_max - c.bit_min) - 2, 1));
        c.check_address = 1'($urandom_range(1));
        load_regs(c);
        random_traffic(160, 45, 25, 20);
    endtask

    task automatic test_default_windows();
        load_regs(DEFAULT_WINDOWS);
        random_traffic(160, 40, 20, 35);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_header_windows();
        test_data_windows();
        test_mixed_traffic();
        test_ring_overflow();
        test_open_windows();
        test_closed_windows();
        test_random_windows();
        test_default_windows();
        repeat (10) @(posedge aclk);
        $display("Sent %0d items, checked %0d results under %0d register settings",
                 items_sent, results_seen, settings_used + 1);
        $display("Ring saw %0d keys, %0d repeat marks, %0d drops when full; %0d frames rejected",
                 keys_pushed, repeats_pushed, pushes_dropped, frames_rejected);
        if (errors == 0 && pending_reports.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
